>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpfa_pkg
// Shared types and constants of the guarded page frame allocator.
// ----------------------------------------------------------------------------
package gpfa_pkg;

  localparam int NUM_FRAMES = 65536;
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int COUNT_W = FRAME_W + 1;
  localparam int PID_W = 16;
  localparam int OWNER_ENTRY_W = PID_W + 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [PID_W-1:0] OWNER_NONE = 16'hFFFF;
  localparam logic [PID_W-1:0] PID_KERNEL = 16'hFFFE;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic CFG_FIRST_USABLE = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] process_id;
    logic [15:0]        frame_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_frame;
  } out_item_t;

endpackage

>>> rtl/gpfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpfa_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpfa_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/guarded_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guarded_page_frame_allocator_core
// Page frame allocator with a LIFO free list and a per-frame owner table.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready as one beat each (opcode, process_id,
// frame_number); every request gives exactly one result beat on
// out_valid/out_ready (status, granted_frame). One request is in work at a
// time and in_ready is low until its result has been loaded.
// A free goes through one owner table read, one write and the output load,
// and skips the write when the frame is outside the window. An allocate
// visits free list entries from the head: each candidate needs two reads of
// the single owner table read port (left and right neighbor) followed by a
// compare step. An allocate on an empty list goes straight to the output load.
// After rst the owner table is swept to "no owner" one entry per cycle, so
// in_ready stays low until the sweep ends; configuration writes on cfg_we are
// taken at any time. If the receiver stalls, the result waits in the output
// register and the block holds its next result until the register empties.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module guarded_page_frame_allocator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gpfa_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gpfa_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [gpfa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gpfa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_A_L, S_A_R, S_A_CHK, S_F_RD, S_F_WR, S_DONE
  } state_t;

  state_t                   state;
  logic [FRAME_W-1:0]       clr;
  logic [15:0]              first_usable;
  logic [16:0]              frame_limit;
  logic [FRAME_W-1:0]       head;
  logic [COUNT_W-1:0]       count;
  logic [FRAME_W-1:0]       cur;
  logic [FRAME_W-1:0]       prev;
  logic [COUNT_W-1:0]       k;
  logic                     left_ok;
  in_item_t                 req;
  out_item_t                res;

  logic                     own_we, own_re, link_we, link_re;
  logic [FRAME_W-1:0]       own_waddr, own_raddr, link_waddr;
  logic [OWNER_ENTRY_W-1:0] own_wdata, own_q;
  logic [FRAME_W-1:0]       link_wdata, link_q;
  logic                     nb_ok, cand_ok, is_kernel, in_window;

  // The owner table carries the on-list flag as its top bit.
  gpfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(OWNER_ENTRY_W)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .re(own_re), .raddr(own_raddr), .rdata(own_q)
  );

  gpfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(FRAME_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(cur), .rdata(link_q)
  );

  assign is_kernel = (req.process_id == PID_KERNEL);
  assign nb_ok = own_q[PID_W-1] || (own_q[PID_W-1:0] == req.process_id);
  assign cand_ok = is_kernel || (left_ok && ((&cur) || nb_ok));
  assign in_window = ({1'b0, req.frame_number} >= {1'b0, first_usable})
                     && ({1'b0, req.frame_number} < frame_limit);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    own_re = 1'b0;
    own_raddr = cur;
    unique case (state)
      S_A_L: begin
        own_re = 1'b1;
        own_raddr = cur - 1'b1;
      end
      S_A_R: begin
        own_re = 1'b1;
        own_raddr = cur + 1'b1;
      end
      S_F_RD: begin
        own_re = 1'b1;
        own_raddr = req.frame_number[FRAME_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    own_we = 1'b0;
    own_waddr = clr;
    own_wdata = {1'b0, OWNER_NONE};
    link_we = 1'b0;
    link_waddr = prev;
    link_wdata = link_q;
    unique case (state)
      S_CLEAR: own_we = 1'b1;
      S_A_CHK: begin
        if (cand_ok) begin
          own_we = 1'b1;
          own_waddr = cur;
          own_wdata = {1'b0, req.process_id};
          link_we = (k != '0);
        end
      end
      S_F_WR: begin
        own_we = 1'b1;
        own_waddr = req.frame_number[FRAME_W-1:0];
        own_wdata = {1'b1, OWNER_NONE};
        link_we = !own_q[PID_W];
        link_waddr = req.frame_number[FRAME_W-1:0];
        link_wdata = head;
      end
      default: ;
    endcase
  end

  assign link_re = (state == S_A_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      first_usable <= '0;
      frame_limit <= 17'd57344;
      head <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_USABLE) begin
          first_usable <= cfg_data[15:0];
        end else begin
          frame_limit <= cfg_data;
        end
      end
      // The result register reloads directly from the done state.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req <= in_item;
            cur <= head;
            k <= '0;
            if (in_item.opcode == OP_FREE) begin
              res <= '0;
              state <= S_F_RD;
            end else if (count == '0) begin
              res <= '{status: ST_NO_FRAME, granted_frame: '0};
              state <= S_DONE;
            end else begin
              res <= '0;
              state <= S_A_L;
            end
          end
        end
        S_A_L: state <= S_A_R;
        S_A_R: begin
          left_ok <= (cur == '0) || nb_ok;
          state <= S_A_CHK;
        end
        S_A_CHK: begin
          if (cand_ok) begin
            if (k == '0) begin
              head <= link_q;
            end
            count <= count - 1'b1;
            res.granted_frame <= cur;
            state <= S_DONE;
          end else if (k + 1'b1 == count) begin
            res.status <= ST_NO_FRAME;
            state <= S_DONE;
          end else begin
            prev <= cur;
            cur <= link_q;
            k <= k + 1'b1;
            state <= S_A_L;
          end
        end
        S_F_RD: begin
          if (in_window) begin
            state <= S_F_WR;
          end else begin
            res.status <= ST_RANGE;
            state <= S_DONE;
          end
        end
        S_F_WR: begin
          if (!own_q[PID_W]) begin
            head <= req.frame_number[FRAME_W-1:0];
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= COUNT_W'(NUM_FRAMES), "free count overflow")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped while stalled")
  `ASSERT_ALWAYS(a_no_accept_in_clear, clk, rst, !(state == S_CLEAR && in_ready), "request taken during clearing sweep")
  `ASSERT_NEXT(a_grant_ok, clk, rst, state == S_A_CHK && cand_ok, res.status == ST_OK && state == S_DONE, "grant not reported as ok")

endmodule
